[rtl/core/lars_pkg.sv]
`timescale 1ns / 1ps

package lars_pkg;

  // Fixed widths of the stream payloads and the width register.
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ROW_WIDTH_W = 6;

  // Default number of cells the block is built for.
  localparam int unsigned ROW_CELLS_DEFAULT = 32;

  // Width register value after reset.
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 6'd20;

  // Neighbor counts of the B3/S23 rule.
  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] STAY_COUNT  = 4'd2;

  // Depth of the result queue; it must hold two results beyond the
  // entries already waiting so that one item can always be taken.
  localparam int unsigned FIFO_DEPTH = 4;

  // One queued result.
  typedef struct packed {
    logic              run_last;
    logic              frame_done;
    logic [DATA_W-1:0] next_row;
  } lars_entry_t;

endpackage

[rtl/core/lars_cell.sv]
`timescale 1ns / 1ps

module lars_cell
  import lars_pkg::*;
(
  input  logic [2:0] above_i,
  input  logic [2:0] mid_i,
  input  logic [2:0] below_i,
  output logic       next_o
);

  logic [3:0] count;

  // Count the eight neighbors; the center of the middle row is the cell itself.
  assign count = {3'b000, above_i[0]} + {3'b000, above_i[1]} + {3'b000, above_i[2]}
               + {3'b000, mid_i[0]} + {3'b000, mid_i[2]}
               + {3'b000, below_i[0]} + {3'b000, below_i[1]} + {3'b000, below_i[2]};

  // Birth on three neighbors, survival on two or three.
  assign next_o = (count == BIRTH_COUNT) || (mid_i[1] && (count == STAY_COUNT));

endmodule

[rtl/core/lars_gen.sv]
`timescale 1ns / 1ps

module lars_gen
  import lars_pkg::*;
#(
  parameter int unsigned LANES = DATA_W
) (
  input  logic [LANES-1:0]  above_i,
  input  logic [LANES-1:0]  mid_i,
  input  logic [LANES-1:0]  below_i,
  input  logic [LANES-1:0]  mask_i,
  output logic [DATA_W-1:0] row_o
);

  logic [LANES+1:0] above_ext;
  logic [LANES+1:0] mid_ext;
  logic [LANES+1:0] below_ext;
  logic [LANES-1:0] lane_next;

  // Mask the rows with the current width and pad a dead cell on each side.
  assign above_ext = {1'b0, above_i & mask_i, 1'b0};
  assign mid_ext   = {1'b0, mid_i & mask_i, 1'b0};
  assign below_ext = {1'b0, below_i & mask_i, 1'b0};

  // One lane per cell, each sees its three-cell window of every row.
  for (genvar c = 0; c < LANES; c++) begin : g_lane
    lars_cell u_cell (
      .above_i (above_ext[c+2:c]),
      .mid_i   (mid_ext[c+2:c]),
      .below_i (below_ext[c+2:c]),
      .next_o  (lane_next[c])
    );
  end

  // Merge the lanes into one row; cells beyond the width read as zero.
  assign row_o = DATA_W'(lane_next & mask_i);

endmodule

[rtl/core/life_automaton_row_step.sv]
`timescale 1ns / 1ps

// One generation of Conway's Life (B3/S23) over a non-wrapping grid.
// Rows enter on the s_axis channel, one row per request, with tlast on the
// bottom row. Each row after the first of a frame yields the next generation
// of the row above it; the bottom row also yields its own, with a dead row
// below, and the frame history is then cleared.
// Results leave on the m_axis channel: tlast marks the bottom row of a frame,
// tuser marks the last result caused by one input row.
// The cfg port sets the number of cells in use (reset value 20); the user is
// to write it only while the block is idle, which the block does not enforce.
// Each result is written into the result queue at the edge that takes its
// input request. All cells of a row are computed by parallel lanes, so one
// row is taken every cycle while the queue has room; a bottom row that closes
// a frame of two or more rows puts two results in the four-entry result queue,
// which then drains at one result per cycle while the receiver is ready.
// s_axis_tready stays high while the queue has room for two results, so a
// stalled receiver holds off the sender once three or four results wait.
// Reset empties the queue, clears the stored rows and sets the width to 20.
module life_automaton_row_step
  import lars_pkg::*;
#(
  parameter int unsigned ROW_CELLS = ROW_CELLS_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Width register write.
  input  logic                   cfg_we_i,
  input  logic [ROW_WIDTH_W-1:0] cfg_wdata_i,
  // Input rows.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [DATA_W-1:0]      s_axis_tdata,   // [31:0] row_cells
  input  logic                   s_axis_tlast,   // last_row
  // Result rows.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [DATA_W-1:0]      m_axis_tdata,   // [31:0] next_row
  output logic                   m_axis_tlast,   // frame_done
  output logic                   m_axis_tuser    // [0] run_last
);

  localparam int unsigned LANES = (ROW_CELLS < DATA_W) ? ROW_CELLS : DATA_W;
  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [ROW_WIDTH_W-1:0] row_width_q;
  logic [ROW_WIDTH_W-1:0] width_eff;
  logic [LANES-1:0]       mask;
  logic [LANES-1:0]       row_in;

  logic [LANES-1:0]       upper_d, upper_q;
  logic [LANES-1:0]       middle_d, middle_q;
  logic                   have_d, have_q;

  logic [LANES-1:0]       upper2;
  logic [DATA_W-1:0]      gen_mid_row;
  logic [DATA_W-1:0]      gen_last_row;

  lars_entry_t            fifo_q [FIFO_DEPTH];
  lars_entry_t            entry_a, entry_b;
  logic [PTR_W-1:0]       wr_ptr_q, wr_ptr_d, wr_ptr_b;
  logic [PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       push_n;
  logic                   accept, pop;

  // Width register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= ROW_WIDTH_RESET;
    end else if (cfg_we_i) begin
      row_width_q <= cfg_wdata_i;
    end
  end

  // Cells in use saturate at the lane count.
  assign width_eff = (row_width_q > ROW_WIDTH_W'(LANES)) ? ROW_WIDTH_W'(LANES) : row_width_q;

  for (genvar c = 0; c < LANES; c++) begin : g_mask
    assign mask[c] = (ROW_WIDTH_W'(c) < width_eff);
  end

  assign row_in = s_axis_tdata[LANES-1:0] & mask;

  // Handshakes.
  assign accept = s_axis_tvalid && s_axis_tready;
  assign pop    = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (count_q <= CNT_W'(FIFO_DEPTH - 2));

  // Next generation of the stored middle row, with the incoming row below.
  lars_gen #(.LANES(LANES)) u_gen_mid (
    .above_i (upper_q),
    .mid_i   (middle_q),
    .below_i (s_axis_tdata[LANES-1:0]),
    .mask_i  (mask),
    .row_o   (gen_mid_row)
  );

  // Next generation of the incoming bottom row, with a dead row below.
  assign upper2 = have_q ? middle_q : '0;

  lars_gen #(.LANES(LANES)) u_gen_last (
    .above_i (upper2),
    .mid_i   (s_axis_tdata[LANES-1:0]),
    .below_i ('0),
    .mask_i  (mask),
    .row_o   (gen_last_row)
  );

  // Row history update.
  always_comb begin
    upper_d  = upper_q;
    middle_d = middle_q;
    have_d   = have_q;
    if (accept) begin
      if (s_axis_tlast) begin
        upper_d  = '0;
        middle_d = '0;
        have_d   = 1'b0;
      end else begin
        upper_d  = upper2;
        middle_d = row_in;
        have_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q  <= '0;
      middle_q <= '0;
      have_q   <= 1'b0;
    end else begin
      upper_q  <= upper_d;
      middle_q <= middle_d;
      have_q   <= have_d;
    end
  end

  // Results of one request: the middle row first, then the bottom row.
  always_comb begin
    entry_b.next_row   = gen_last_row;
    entry_b.frame_done = 1'b1;
    entry_b.run_last   = 1'b1;
    if (have_q) begin
      entry_a.next_row   = gen_mid_row;
      entry_a.frame_done = 1'b0;
      entry_a.run_last   = !s_axis_tlast;
    end else begin
      entry_a = entry_b;
    end
    push_n = accept ? (CNT_W'(have_q) + CNT_W'(s_axis_tlast)) : '0;
  end

  // Result queue pointers and fill count.
  assign wr_ptr_b = wr_ptr_q + PTR_W'(1);
  assign wr_ptr_d = wr_ptr_q + PTR_W'(push_n);
  assign rd_ptr_d = pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
  assign count_d  = count_q + push_n - CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_n != '0) begin
      fifo_q[wr_ptr_q] <= entry_a;
    end
    if (push_n == CNT_W'(2)) begin
      fifo_q[wr_ptr_b] <= entry_b;
    end
  end

  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tdata  = fifo_q[rd_ptr_q].next_row;
  assign m_axis_tlast  = fifo_q[rd_ptr_q].frame_done;
  assign m_axis_tuser  = fifo_q[rd_ptr_q].run_last;

  // The queue never overfills.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  // A bottom row ends the frame and clears the history.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tlast |=> !have_q && (middle_q == '0) && (upper_q == '0))
    else $error("history not cleared at end of frame");

  // Any other row leaves a stored middle row behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !s_axis_tlast |=> have_q)
    else $error("middle row not kept");

  // The fill count follows the requests taken and the results delivered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count_q == $past(count_q) + $past(push_n) - CNT_W'($past(pop)))
    else $error("result queue count mismatch");

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
  import lars_pkg::*;

  localparam int unsigned CELLS        = ROW_CELLS_DEFAULT;
  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned PRINT_LIMIT  = 100;

  // One row of the directed plan. A width write precedes the row when set_w
  // is high; typed rows close a single-row frame whose result is known.
  typedef struct packed {
    logic                   set_w;
    logic [ROW_WIDTH_W-1:0] w;
    logic [DATA_W-1:0]      cells;
    logic                   last;
    logic                   typed;
    logic [DATA_W-1:0]      want;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [ROW_WIDTH_W-1:0] cfg_wdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [DATA_W-1:0]      s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [DATA_W-1:0]      m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   m_axis_tuser;

  // Mirror of the block state used to work out the next generation.
  logic [DATA_W-1:0]      upper_row   = '0;
  logic [DATA_W-1:0]      middle_row  = '0;
  logic                   have_middle = 1'b0;
  logic [ROW_WIDTH_W-1:0] width_q     = ROW_WIDTH_RESET;

  lars_entry_t            next_rows_q[$];
  lars_entry_t            got_row;
  lars_entry_t            want_row;

  logic                   typed_on   = 1'b0;
  logic [DATA_W-1:0]      typed_want = '0;
  bit                     no_idle    = 1'b0;
  int unsigned            errors     = 0;
  int unsigned            idle_cycles = 0;
  int unsigned            stall_left = 0;

  plan_row_t              plan[24];

  life_automaton_row_step #(
    .ROW_CELLS(CELLS)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #1 clk = ~clk;

  // Number of live lanes: the register saturates at the built size and 32.
  function automatic int cells_in_use();
    int w;
    w = int'(width_q);
    if (w > int'(CELLS)) w = int'(CELLS);
    if (w > DATA_W) w = DATA_W;
    return w;
  endfunction

  function automatic logic [DATA_W-1:0] lane_mask();
    int w;
    w = cells_in_use();
    if (w == 0) return '0;
    if (w >= DATA_W) return '1;
    return (DATA_W'(1) << w) - DATA_W'(1);
  endfunction

  // Cells outside the row read as dead.
  function automatic int cell_at(input logic [DATA_W-1:0] row, input int c);
    if (c < 0 || c >= DATA_W) return 0;
    return int'(row[c]);
  endfunction

  // One B3/S23 generation of the middle row between its two neighbors.
  function automatic logic [DATA_W-1:0] life_next(input logic [DATA_W-1:0] above,
                                                  input logic [DATA_W-1:0] mid,
                                                  input logic [DATA_W-1:0] below);
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] res;
    int                w;
    int                n;
    m     = lane_mask();
    w     = cells_in_use();
    res   = '0;
    above = above & m;
    mid   = mid & m;
    below = below & m;
    for (int c = 0; c < w; c++) begin
      n = cell_at(above, c - 1) + cell_at(above, c) + cell_at(above, c + 1)
        + cell_at(mid, c - 1) + cell_at(mid, c + 1)
        + cell_at(below, c - 1) + cell_at(below, c) + cell_at(below, c + 1);
      if (mid[c]) begin
        res[c] = (n == int'(STAY_COUNT)) || (n == int'(BIRTH_COUNT));
      end else begin
        res[c] = (n == int'(BIRTH_COUNT));
      end
    end
    return res;
  endfunction

  // Advance the mirrored grid by one accepted row and queue its results.
  function automatic void take_row(input logic [DATA_W-1:0] cells, input logic last);
    logic [DATA_W-1:0] row;
    lars_entry_t       e;
    row = cells & lane_mask();
    if (have_middle) begin
      e.next_row   = life_next(upper_row, middle_row, row);
      e.frame_done = 1'b0;
      e.run_last   = !last;
      next_rows_q.push_back(e);
      upper_row = middle_row;
    end else begin
      upper_row = '0;
    end
    middle_row  = row;
    have_middle = 1'b1;
    if (last) begin
      e.next_row   = typed_on ? typed_want : life_next(upper_row, middle_row, '0);
      e.frame_done = 1'b1;
      e.run_last   = 1'b1;
      next_rows_q.push_back(e);
      upper_row   = '0;
      middle_row  = '0;
      have_middle = 1'b0;
    end
  endfunction

  task automatic report(input string what, input logic [DATA_W-1:0] got,
                        input logic [DATA_W-1:0] want);
    if (errors < PRINT_LIMIT) begin
      $display("%0t ERROR %s: got %h, want %h", $time, what, got, want);
    end
    errors++;
  endtask

  // Mostly short gaps, a few long ones, none in the no-idle stretches.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Input and output requests, checked at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (s_axis_tvalid && s_axis_tready) begin
        take_row(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_row.next_row   = m_axis_tdata;
        got_row.frame_done = m_axis_tlast;
        got_row.run_last   = m_axis_tuser;
        if (next_rows_q.size() == 0) begin
          report("result with nothing expected", got_row.next_row, '0);
        end else begin
          want_row = next_rows_q.pop_front();
          if (got_row.next_row !== want_row.next_row) begin
            report("next_row", got_row.next_row, want_row.next_row);
          end
          if (got_row.frame_done !== want_row.frame_done) begin
            report("frame_done", DATA_W'(got_row.frame_done), DATA_W'(want_row.frame_done));
          end
          if (got_row.run_last !== want_row.run_last) begin
            report("run_last", DATA_W'(got_row.run_last), DATA_W'(want_row.run_last));
          end
        end
      end
      if (cfg_we) begin
        width_q = cfg_wdata;
      end
    end
  end

  // Watchdog on cycles without any request on either side.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result receiver with random stalls.
  always @(negedge clk) begin
    if (no_idle || stall_left == 0) begin
      m_axis_tready <= 1'b1;
      if (!no_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end else begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end
  end

  // Send one row after a random gap and wait for its request to complete.
  task automatic push_row(input logic [DATA_W-1:0] cells, input logic last,
                          input logic typed, input logic [DATA_W-1:0] want);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    typed_on      = typed;
    typed_want    = want;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= cells;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
  endtask

  // Stop sending and let every queued result drain, plus the block latency.
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (next_rows_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_width(input logic [ROW_WIDTH_W-1:0] w);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [DATA_W-1:0]      cells;
    logic [ROW_WIDTH_W-1:0] w;
    int unsigned            sent;
    int unsigned            frame_left;
    int unsigned            r;

    // Single-row frames, frames of several rows, masking, saturated and zero
    // width, and a width change in the middle of a frame.
    plan = '{
      '{1'b0, 6'd0,  32'h000F_FFFF, 1'b1, 1'b1, 32'h0007_FFFE},
      '{1'b0, 6'd0,  32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
      '{1'b0, 6'd0,  32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0007_FFFE},
      '{1'b0, 6'd0,  32'h0000_0002, 1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd0,  32'h0000_0004, 1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd0,  32'h0000_0007, 1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd0,  32'h0000_0000, 1'b1, 1'b0, 32'h0},
      '{1'b0, 6'd0,  32'h000F_FFFF, 1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd0,  32'h000F_FFFF, 1'b1, 1'b0, 32'h0},
      '{1'b1, 6'd63, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFE},
      '{1'b0, 6'd0,  32'h8000_0001, 1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd0,  32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd0,  32'h8000_0001, 1'b1, 1'b0, 32'h0},
      '{1'b1, 6'd0,  32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000},
      '{1'b0, 6'd0,  32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd0,  32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
      '{1'b1, 6'd1,  32'h0000_0001, 1'b1, 1'b1, 32'h0000_0000},
      '{1'b1, 6'd32, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd0,  32'h5555_5555, 1'b0, 1'b0, 32'h0},
      '{1'b1, 6'd3,  32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
      '{1'b1, 6'd33, 32'hE000_0007, 1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd0,  32'hE000_0007, 1'b0, 1'b0, 32'h0},
      '{1'b0, 6'd0,  32'hE000_0007, 1'b1, 1'b0, 32'h0},
      '{1'b1, 6'd2,  32'h0000_0003, 1'b1, 1'b1, 32'h0000_0000}
    };

    // Reset once at the start.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(plan); i++) begin
      if (plan[i].set_w) set_width(plan[i].w);
      push_row(plan[i].cells, plan[i].last, plan[i].typed, plan[i].want);
    end

    // Random frames in phases, each phase under a new width. Frames run on
    // across phase boundaries, so widths also change mid-frame.
    sent       = 0;
    frame_left = 0;
    while (sent < RANDOM_ITEMS || frame_left != 0) begin
      no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0:       w = '0;
        1:       w = ROW_WIDTH_W'(1);
        2:       w = ROW_WIDTH_W'(DATA_W);
        3:       w = '1;
        4:       w = ROW_WIDTH_W'($urandom_range(33, 63));
        default: w = ROW_WIDTH_W'($urandom_range(1, 32));
      endcase
      set_width(w);
      repeat ($urandom_range(60, 140)) begin
        if (frame_left == 0) begin
          if (sent >= RANDOM_ITEMS) break;
          r = $urandom_range(0, 99);
          if (r < 50) frame_left = $urandom_range(1, 4);
          else if (r < 85) frame_left = $urandom_range(5, 12);
          else frame_left = $urandom_range(13, 40);
        end
        case ($urandom_range(0, 5))
          0:       cells = $urandom() & $urandom();
          1:       cells = $urandom() | $urandom();
          2:       cells = DATA_W'(7) << $urandom_range(0, 29);
          3:       cells = ($urandom_range(0, 1) == 0) ? '0 : '1;
          default: cells = $urandom();
        endcase
        push_row(cells, frame_left == 1, 1'b0, '0);
        frame_left--;
        sent++;
      end
    end

    settle();
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
